FILE: rtl/rft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// rft_pkg: shared types and constants of the rail fence transposer
// no dependencies

package rft_pkg;

    localparam int BYTE_W = 8;
    localparam int RAIL_W = 7;
    localparam int STEP_W = RAIL_W + 1;

    localparam logic REG_RAIL_COUNT   = 1'b0;
    localparam logic REG_DECRYPT_MODE = 1'b1;

    localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = 7'd2;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_SEEK  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } rft_state_t;

    typedef struct packed {
        logic init;
        logic adv;
    } rft_walk_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/rft_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// rft_in_if / rft_out_if: valid-ready channels of the rail fence transposer
// depends on rft_pkg

interface rft_in_if;
    logic                      valid;
    logic                      ready;
    logic [rft_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rft_out_if;
    logic                      valid;
    logic                      ready;
    logic [rft_pkg::BYTE_W-1:0] out_byte;
    logic                      last_out;
    logic                      overflow;

    modport source (output valid, output out_byte, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input last_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/rail_fence_transposer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// rail_fence_transposer_unit: buffers a message and emits its rail fence permutation
// depends on rft_pkg, rft_in_if, rft_out_if, rft_zigzag_walker
//
// usage:
//   in_chan takes one message byte per transaction, end_of_message on the final one.
//   in_chan is ready only while loading; non-final bytes give no output transaction.
//   after the final byte the block stops taking input and walks the zigzag with a
//   single position stepper: encrypt reads the buffer in rail order and emits each
//   byte as it is read; decrypt first scatters the buffer along the walk into a
//   second memory, then reads it out in order. out_chan carries out_byte,
//   last_out on the final byte and overflow on every byte of a truncated message.
//   bytes beyond MAX_LEN are dropped. a stall on out_chan holds the output register
//   and pauses the walk; input is taken again once the final byte sits in the
//   output register. rail_count and decrypt_mode are written through the apb port;
//   the user must write them only while idle, the block itself does not enforce
//   it. reset empties the buffer count, clears overflow, sets rail_count 2 and
//   encrypt; no memory clearing pass is done.

module rail_fence_transposer_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    rft_in_if.sink                       in_chan,
    rft_out_if.source                    out_chan
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = ((CW > rft_pkg::STEP_W) ? CW : rft_pkg::STEP_W) + 1;

    // configuration
    logic [rft_pkg::RAIL_W-1:0] rail_count_reg;
    logic                       decrypt_mode_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_count_reg   <= rft_pkg::RAIL_COUNT_RESET;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                rft_pkg::REG_RAIL_COUNT:   rail_count_reg   <= pwdata[rft_pkg::RAIL_W-1:0];
                rft_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default:                   rail_count_reg   <= rail_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rft_pkg::REG_RAIL_COUNT:   prdata = {25'd0, rail_count_reg};
            rft_pkg::REG_DECRYPT_MODE: prdata = {31'd0, decrypt_mode_reg};
            default:                   prdata = '0;
        endcase
    end

    // control state
    rft_pkg::rft_state_t state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       dest_reg, dest_next;

    logic                       out_valid_reg, out_valid_next;
    logic [rft_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_ovf_reg, out_ovf_next;

    logic                       in_take;
    logic                       room;
    logic                       slot_free;
    logic                       cnt_last;

    // memories
    logic [rft_pkg::BYTE_W-1:0] store_mem [MAX_LEN];
    logic [rft_pkg::BYTE_W-1:0] result_mem [MAX_LEN];
    logic [rft_pkg::BYTE_W-1:0] store_q;
    logic [rft_pkg::BYTE_W-1:0] result_q;
    logic                       store_rd;
    logic [AW-1:0]              store_rd_addr;
    logic                       result_wr;
    logic                       result_rd;

    // walker
    rft_pkg::rft_walk_ctl_t walk_ctl;
    logic [PW-1:0]          walk_pos;
    logic                   walk_valid;

    rft_zigzag_walker #(
        .MAX_LEN (MAX_LEN)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (walk_ctl),
        .rails     (rail_count_reg),
        .msg_len   (fill_reg),
        .pos       (walk_pos),
        .pos_valid (walk_valid)
    );

    assign in_chan.ready  = (state_reg == rft_pkg::ST_LOAD);
    assign in_take        = in_chan.valid && in_chan.ready;
    assign room           = (fill_reg < CW'(MAX_LEN));
    assign slot_free      = !out_valid_reg || out_chan.ready;
    assign cnt_last       = (cnt_reg + CW'(1) == fill_reg);

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.out_byte = out_byte_reg;
    assign out_chan.last_out = out_last_reg;
    assign out_chan.overflow = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        dest_next      = dest_reg;
        out_valid_next = out_valid_reg && !out_chan.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        walk_ctl.init  = 1'b0;
        walk_ctl.adv   = 1'b0;
        store_rd       = 1'b0;
        store_rd_addr  = walk_pos[AW-1:0];
        result_wr      = 1'b0;
        result_rd      = 1'b0;

        case (state_reg)
            rft_pkg::ST_LOAD:
            begin
                if (in_take)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_chan.end_of_message)
                    begin
                        walk_ctl.init = 1'b1;
                        cnt_next      = '0;
                        state_next    = rft_pkg::ST_SEEK;
                    end
                end
            end
            rft_pkg::ST_SEEK:
            begin
                walk_ctl.adv = 1'b1;
                if (walk_valid)
                begin
                    store_rd  = 1'b1;
                    dest_next = walk_pos[AW-1:0];
                    if (decrypt_mode_reg)
                    begin
                        store_rd_addr = cnt_reg[AW-1:0];
                        state_next    = rft_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = rft_pkg::ST_EMIT;
                    end
                end
            end
            rft_pkg::ST_WRITE:
            begin
                result_wr = 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = rft_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = rft_pkg::ST_SEEK;
                end
            end
            rft_pkg::ST_DRAIN:
            begin
                result_rd  = 1'b1;
                state_next = rft_pkg::ST_EMIT;
            end
            rft_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = decrypt_mode_reg ? result_q : store_q;
                    out_last_next  = cnt_last;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = cnt_reg + CW'(1);
                    if (cnt_last)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = rft_pkg::ST_LOAD;
                    end
                    else if (decrypt_mode_reg)
                    begin
                        state_next = rft_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        state_next = rft_pkg::ST_SEEK;
                    end
                end
            end
            default:
            begin
                state_next = rft_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rft_pkg::ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg     <= dest_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // message buffer
    always_ff @(posedge clk)
    begin
        if (in_take && room)
        begin
            store_mem[fill_reg[AW-1:0]] <= in_chan.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_rd)
        begin
            store_q <= store_mem[store_rd_addr];
        end
    end

    // decrypt scatter buffer
    always_ff @(posedge clk)
    begin
        if (result_wr)
        begin
            result_mem[dest_reg] <= store_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_rd)
        begin
            result_q <= result_mem[cnt_reg[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rft_zigzag_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// rft_zigzag_walker: steps through zigzag positions rail by rail, one step a cycle while ctl.adv is set
// depends on rft_pkg

module rft_zigzag_walker #(
    parameter int MAX_LEN = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire rft_pkg::rft_walk_ctl_t  ctl,
    input  wire [rft_pkg::RAIL_W-1:0]    rails,
    input  wire [$clog2(MAX_LEN+1)-1:0]  msg_len,
    output logic [((($clog2(MAX_LEN+1)) > rft_pkg::STEP_W) ?
                   $clog2(MAX_LEN+1) : rft_pkg::STEP_W):0] pos,
    output logic                         pos_valid
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = ((CW > rft_pkg::STEP_W) ? CW : rft_pkg::STEP_W) + 1;

    logic [PW-1:0]              pos_reg, pos_next;
    logic [rft_pkg::RAIL_W-1:0] rail_reg, rail_next;
    logic                       phase_reg, phase_next;

    logic                       pass;
    logic                       edge_rail;
    logic [rft_pkg::STEP_W-1:0] period;
    logic [rft_pkg::STEP_W-1:0] twice_rail;
    logic [rft_pkg::STEP_W-1:0] step;

    assign pass       = (rails <= rft_pkg::RAIL_W'(1));
    assign period     = {rails - rft_pkg::RAIL_W'(1), 1'b0};
    assign twice_rail = {rail_reg, 1'b0};
    assign edge_rail  = (rail_reg == '0) || (rail_reg == rails - rft_pkg::RAIL_W'(1));
    assign pos_valid  = (pos_reg < PW'(msg_len));
    assign pos        = pos_reg;

    always_comb
    begin
        if (pass)
        begin
            step = rft_pkg::STEP_W'(1);
        end
        else if (edge_rail)
        begin
            step = period;
        end
        else if (phase_reg)
        begin
            step = twice_rail;
        end
        else
        begin
            step = period - twice_rail;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        rail_next  = rail_reg;
        phase_next = phase_reg;
        if (ctl.init)
        begin
            pos_next   = '0;
            rail_next  = '0;
            phase_next = 1'b0;
        end
        else if (ctl.adv)
        begin
            if (pos_valid)
            begin
                pos_next   = pos_reg + PW'(step);
                phase_next = ~phase_reg;
            end
            else
            begin
                // move to the next rail
                rail_next  = rail_reg + rft_pkg::RAIL_W'(1);
                pos_next   = PW'(rail_reg) + PW'(1);
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            rail_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            rail_reg  <= rail_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_rail_fence_transposer_unit.sv
`timescale 1ns / 1ps
// tb_rail_fence_transposer_unit: self-checking bench for the rail fence transposer
// predicts each permuted message from the buffered bytes and checks every output transaction
// depends on rft_pkg, rft_in_if, rft_out_if and rail_fence_transposer_unit

module tb_rail_fence_transposer_unit;

    localparam int MAX_LEN       = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_SETTINGS  = 16;

    localparam logic [2:0] ADDR_RAIL_COUNT   = {rft_pkg::REG_RAIL_COUNT, 2'b00};
    localparam logic [2:0] ADDR_DECRYPT_MODE = {rft_pkg::REG_DECRYPT_MODE, 2'b00};

    typedef struct {
        logic [rft_pkg::BYTE_W-1:0] value;
        logic                       eom;
    } plain_byte_t;

    typedef struct {
        logic [rft_pkg::BYTE_W-1:0] value;
        logic                       last;
        logic                       trunc;
    } permuted_byte_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rft_in_if  in_ch ();
    rft_out_if out_ch ();

    rail_fence_transposer_unit #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_ch),
        .out_chan (out_ch)
    );

    plain_byte_t    byte_feed [$];
    permuted_byte_t permuted_due [$];
    plain_byte_t    next_plain;
    permuted_byte_t want;

    logic [rft_pkg::BYTE_W-1:0] msg_buf [MAX_LEN];
    int unsigned                held_count;
    logic                       trunc_flag;
    logic [rft_pkg::RAIL_W-1:0] cfg_rails;
    logic                       cfg_decrypt;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int cycle_count;

    int plan_rails   [NUM_SETTINGS] = '{1, 0, 2, 3, 3, 4, 64, 65, 127, 127, 5, 6, 1, 63, 2, 7};
    int plan_decrypt [NUM_SETTINGS] = '{0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 1, 1, 0, 0};
    int plan_long    [NUM_SETTINGS] = '{0, 0, 0, 0, 0, 66, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned rail_of_position(input int unsigned pos,
                                                     input int unsigned rails);
        int unsigned period;
        int unsigned m;
        period = 2 * (rails - 1);
        m = pos % period;
        return (m < rails) ? m : period - m;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic absorb_byte(input logic [rft_pkg::BYTE_W-1:0] value, input logic eom);
        logic [rft_pkg::BYTE_W-1:0] perm [MAX_LEN];
        int unsigned                walk [MAX_LEN];
        int unsigned                n;
        int unsigned                k;
        int unsigned                r;
        int unsigned                i;
        if (held_count < MAX_LEN)
        begin
            msg_buf[held_count] = value;
            held_count++;
        end
        else
            trunc_flag = 1'b1;
        if (!eom)
            return;
        n = held_count;
        if (cfg_rails <= 1)
        begin
            for (i = 0; i < n; i++)
                perm[i] = msg_buf[i];
        end
        else
        begin
            k = 0;
            for (r = 0; r < cfg_rails; r++)
                for (i = 0; i < n; i++)
                    if (rail_of_position(i, cfg_rails) == r && k < n)
                    begin
                        walk[k] = i;
                        k++;
                    end
            for (k = 0; k < n; k++)
            begin
                if (cfg_decrypt)
                    perm[walk[k]] = msg_buf[k];
                else
                    perm[k] = msg_buf[walk[k]];
            end
        end
        for (k = 0; k < n; k++)
            permuted_due.push_back('{perm[k], (k + 1 == n), trunc_flag});
        held_count = 0;
        trunc_flag = 1'b0;
    endtask

    // driver: one transaction per accept, predictor fed on each accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.data_byte      <= '0;
            in_ch.end_of_message <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                absorb_byte(in_ch.data_byte, in_ch.end_of_message);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_plain = byte_feed.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.data_byte      <= next_plain.value;
                    in_ch.end_of_message <= next_plain.eom;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (permuted_due.size() == 0)
                    flag_mismatch($sformatf("unexpected transaction, out_byte %02h",
                                            out_ch.out_byte));
                else
                begin
                    want = permuted_due.pop_front();
                    if (out_ch.out_byte !== want.value)
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                out_ch.out_byte, want.value));
                    if (out_ch.last_out !== want.last)
                        flag_mismatch($sformatf("last_out %b, expected %b",
                                                out_ch.last_out, want.last));
                    if (out_ch.overflow !== want.trunc)
                        flag_mismatch($sformatf("overflow %b, expected %b",
                                                out_ch.overflow, want.trunc));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_RAIL_COUNT)
            cfg_rails = value[rft_pkg::RAIL_W-1:0];
        else
            cfg_decrypt = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        while (byte_feed.size() != 0 || in_ch.valid || permuted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_message(input int len);
        int i;
        for (i = 0; i < len; i++)
            byte_feed.push_back('{rft_pkg::BYTE_W'($urandom_range(255)), (i == len - 1)});
    endtask

    initial
    begin
        string probe;
        int    s;
        int    i;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        held_count     = 0;
        trunc_flag     = 1'b0;
        cfg_rails      = rft_pkg::RAIL_COUNT_RESET;
        cfg_decrypt    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two rails, encrypt
        byte_feed.push_back('{8'h00, 1'b1});
        byte_feed.push_back('{8'hFF, 1'b0});
        byte_feed.push_back('{8'h00, 1'b1});
        byte_feed.push_back('{8'h55, 1'b0});
        byte_feed.push_back('{8'hAA, 1'b0});
        byte_feed.push_back('{8'h0F, 1'b0});
        byte_feed.push_back('{8'hF0, 1'b0});
        byte_feed.push_back('{8'h01, 1'b1});
        probe = "WEAREDISCOVERED";
        for (i = 0; i < probe.len(); i++)
            byte_feed.push_back('{probe[i], (i == probe.len() - 1)});
        wait_quiet();

        for (s = 0; s < NUM_SETTINGS; s++)
        begin
            write_reg(ADDR_RAIL_COUNT, ($urandom() & ~32'h7F) | 32'(plan_rails[s]));
            write_reg(ADDR_DECRYPT_MODE, ($urandom() & ~32'h1) | 32'(plan_decrypt[s]));
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            queue_message($urandom_range(1, 4));
            if (plan_long[s] != 0)
                queue_message(plan_long[s]);
            wait_quiet();
        end

        repeat (64) @(posedge clk);
        if (permuted_due.size() != 0)
            flag_mismatch($sformatf("%0d output transactions never arrived",
                                    permuted_due.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/rft_pkg.sv
rtl/rft_stream_if.sv
rtl/rft_zigzag_walker.sv
rtl/rail_fence_transposer_unit.sv
test/tb_rail_fence_transposer_unit.sv
